// ----- hw/rtl/line_intersection_point_top_assert.svh -----
// assertion macros for the intersection pipeline
`ifndef LINE_INTERSECTION_POINT_TOP_ASSERT_SVH
`define LINE_INTERSECTION_POINT_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define LIP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition in one cycle implies another in the next
`define LIP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hw/rtl/lip_pkg.sv -----
package lip_pkg;

    localparam int COORD_BITS_DEF = 24;

    typedef enum logic [2:0] {
        CASE_BOTH_VERT  = 3'd0,
        CASE_FIRST_VERT = 3'd1,
        CASE_SEC_VERT   = 3'd2,
        CASE_BOTH_HORZ  = 3'd3,
        CASE_FIRST_HORZ = 3'd4,
        CASE_SEC_HORZ   = 3'd5,
        CASE_GENERAL    = 3'd6
    } case_t;

endpackage

// ----- hw/rtl/line_intersection_point_top.sv -----
// Crossing point of two lines, each given by two signed fixed point points. A request is
// accepted in every cycle that s_tready is high and passes through stages 1 to 6, the
// restoring divider, the sign stage and the output register. The divider resolves one
// quotient bit per pipeline stage over the full product width, run for x and y side
// by side. The whole pipeline advances when the output register is empty or taken, so a
// stall on the master side holds every stage. case_taken tells which special case
// produced the result; parallel_flag marks a zero general denominator, in which case the
// first point of the first line is returned. Results saturate to the coordinate range.
module line_intersection_point_top #(
    parameter int COORD_BITS = lip_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [8*COORD_BITS-1:0]             s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // cross_x, cross_y, zero pad
    output logic [((2*COORD_BITS+7)/8)*8-1:0]   m_tdata,
    // case_taken, parallel_flag
    output logic [3:0]                          m_tuser
);
    import lip_pkg::*;

    localparam int W     = COORD_BITS;
    localparam int DW    = W + 1;
    localparam int PW    = 2 * DW + 1;
    localparam int NW    = PW + DW;
    localparam int KL    = PW / 2;
    localparam int KH    = PW - KL;
    localparam int OUT_W = ((2 * W + 7) / 8) * 8;
    localparam logic signed [NW+1:0] SMAX = {{(NW+3-W){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [NW+1:0] SMIN = {{(NW+3-W){1'b1}}, {(W-1){1'b0}}};

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic signed [W-1:0] in_asx, in_asy, in_aex, in_aey, in_bsx, in_bsy, in_bex, in_bey;
    assign in_asx = $signed(s_tdata[0*W +: W]);
    assign in_asy = $signed(s_tdata[1*W +: W]);
    assign in_aex = $signed(s_tdata[2*W +: W]);
    assign in_aey = $signed(s_tdata[3*W +: W]);
    assign in_bsx = $signed(s_tdata[4*W +: W]);
    assign in_bsy = $signed(s_tdata[5*W +: W]);
    assign in_bex = $signed(s_tdata[6*W +: W]);
    assign in_bey = $signed(s_tdata[7*W +: W]);

    // stage 1: shift to origin
    logic v1_reg;
    logic signed [W-1:0]  ox1_reg, oy1_reg;
    logic signed [DW-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg, ex1_reg, ey1_reg;
    logic signed [DW-1:0] dx1_reg, dy1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ox1_reg <= in_asx;
            oy1_reg <= in_asy;
            ax1_reg <= DW'(in_aex) - DW'(in_asx);
            ay1_reg <= DW'(in_aey) - DW'(in_asy);
            bx1_reg <= DW'(in_bsx) - DW'(in_asx);
            by1_reg <= DW'(in_bsy) - DW'(in_asy);
            ex1_reg <= DW'(in_bex) - DW'(in_asx);
            ey1_reg <= DW'(in_bey) - DW'(in_asy);
            dx1_reg <= DW'(in_bex) - DW'(in_bsx);
            dy1_reg <= DW'(in_bey) - DW'(in_bsy);
        end
    end

    // stage 2: products and case choice
    case_t sel2_next;
    always_comb
    begin
        if (ax1_reg == '0 && dx1_reg == '0)
            sel2_next = CASE_BOTH_VERT;
        else if (ax1_reg == '0)
            sel2_next = CASE_FIRST_VERT;
        else if (dx1_reg == '0)
            sel2_next = CASE_SEC_VERT;
        else if (ay1_reg == '0 && dy1_reg == '0)
            sel2_next = CASE_BOTH_HORZ;
        else if (ay1_reg == '0)
            sel2_next = CASE_FIRST_HORZ;
        else if (dy1_reg == '0)
            sel2_next = CASE_SEC_HORZ;
        else
            sel2_next = CASE_GENERAL;
    end

    logic v2_reg;
    case_t sel2_reg;
    logic signed [W-1:0]  ox2_reg, oy2_reg;
    logic signed [DW-1:0] ax2_reg, ay2_reg, bx2_reg, by2_reg, dx2_reg, dy2_reg;
    logic signed [PW-1:0] pbxey2_reg, pexby2_reg, pbxay2_reg, pbyax2_reg;
    logic signed [PW-1:0] paydx2_reg, pdyax2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel2_reg   <= sel2_next;
            ox2_reg    <= ox1_reg;
            oy2_reg    <= oy1_reg;
            ax2_reg    <= ax1_reg;
            ay2_reg    <= ay1_reg;
            bx2_reg    <= bx1_reg;
            by2_reg    <= by1_reg;
            dx2_reg    <= dx1_reg;
            dy2_reg    <= dy1_reg;
            pbxey2_reg <= bx1_reg * ey1_reg;
            pexby2_reg <= ex1_reg * by1_reg;
            pbxay2_reg <= bx1_reg * ay1_reg;
            pbyax2_reg <= by1_reg * ax1_reg;
            paydx2_reg <= ay1_reg * dx1_reg;
            pdyax2_reg <= dy1_reg * ax1_reg;
        end
    end

    // stage 3: cross term and general denominator
    logic v3_reg;
    case_t sel3_reg;
    logic signed [W-1:0]  ox3_reg, oy3_reg;
    logic signed [DW-1:0] ax3_reg, ay3_reg, bx3_reg, by3_reg, dx3_reg, dy3_reg;
    logic signed [PW-1:0] pbxay3_reg, pbyax3_reg, c3_reg, den3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel3_reg   <= sel2_reg;
            ox3_reg    <= ox2_reg;
            oy3_reg    <= oy2_reg;
            ax3_reg    <= ax2_reg;
            ay3_reg    <= ay2_reg;
            bx3_reg    <= bx2_reg;
            by3_reg    <= by2_reg;
            dx3_reg    <= dx2_reg;
            dy3_reg    <= dy2_reg;
            pbxay3_reg <= pbxay2_reg;
            pbyax3_reg <= pbyax2_reg;
            c3_reg     <= pbxey2_reg - pexby2_reg;
            den3_reg   <= paydx2_reg - pdyax2_reg;
        end
    end

    // stage 4: partial products of the cross term
    logic v4_reg;
    case_t sel4_reg;
    logic signed [W-1:0]     ox4_reg, oy4_reg;
    logic signed [DW-1:0]    ax4_reg, ay4_reg, bx4_reg, by4_reg, dx4_reg, dy4_reg;
    logic signed [PW-1:0]    pbxay4_reg, pbyax4_reg, c4_reg, den4_reg;
    logic signed [KH+DW-1:0] pay_h4_reg, pax_h4_reg;
    logic signed [KL+DW:0]   pay_l4_reg, pax_l4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel4_reg   <= sel3_reg;
            ox4_reg    <= ox3_reg;
            oy4_reg    <= oy3_reg;
            ax4_reg    <= ax3_reg;
            ay4_reg    <= ay3_reg;
            bx4_reg    <= bx3_reg;
            by4_reg    <= by3_reg;
            dx4_reg    <= dx3_reg;
            dy4_reg    <= dy3_reg;
            pbxay4_reg <= pbxay3_reg;
            pbyax4_reg <= pbyax3_reg;
            c4_reg     <= c3_reg;
            den4_reg   <= den3_reg;
            pay_h4_reg <= $signed(c3_reg[PW-1:KL]) * ay3_reg;
            pax_h4_reg <= $signed(c3_reg[PW-1:KL]) * ax3_reg;
            pay_l4_reg <= $signed({1'b0, c3_reg[KL-1:0]}) * ay3_reg;
            pax_l4_reg <= $signed({1'b0, c3_reg[KL-1:0]}) * ax3_reg;
        end
    end

    // stage 5: full cross products
    logic v5_reg;
    case_t sel5_reg;
    logic signed [W-1:0]  ox5_reg, oy5_reg;
    logic signed [DW-1:0] ax5_reg, ay5_reg, bx5_reg, by5_reg, dx5_reg, dy5_reg;
    logic signed [PW-1:0] pbxay5_reg, pbyax5_reg, c5_reg, den5_reg;
    logic signed [NW-1:0] cay5_reg, cax5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel5_reg   <= sel4_reg;
            ox5_reg    <= ox4_reg;
            oy5_reg    <= oy4_reg;
            ax5_reg    <= ax4_reg;
            ay5_reg    <= ay4_reg;
            bx5_reg    <= bx4_reg;
            by5_reg    <= by4_reg;
            dx5_reg    <= dx4_reg;
            dy5_reg    <= dy4_reg;
            pbxay5_reg <= pbxay4_reg;
            pbyax5_reg <= pbyax4_reg;
            c5_reg     <= c4_reg;
            den5_reg   <= den4_reg;
            cay5_reg   <= (NW'(pay_h4_reg) <<< KL) + NW'(pay_l4_reg);
            cax5_reg   <= (NW'(pax_h4_reg) <<< KL) + NW'(pax_l4_reg);
        end
    end

    // stage 6: pick dividend and divisor per coordinate
    logic signed [NW-1:0] nx_next, ny_next;
    logic signed [PW-1:0] dvx_next, dvy_next;
    logic                 negx_next, negy_next, par_next;

    always_comb
    begin
        nx_next   = '0;
        ny_next   = '0;
        dvx_next  = PW'(1);
        dvy_next  = PW'(1);
        negx_next = 1'b0;
        negy_next = 1'b0;
        par_next  = 1'b0;
        case (sel5_reg)
            CASE_BOTH_VERT:
            begin
                ny_next = NW'(ay5_reg);
            end
            CASE_FIRST_VERT:
            begin
                ny_next   = NW'(c5_reg);
                dvy_next  = PW'(dx5_reg);
                negy_next = 1'b1;
            end
            CASE_SEC_VERT:
            begin
                nx_next  = NW'(bx5_reg);
                ny_next  = NW'(pbxay5_reg);
                dvy_next = PW'(ax5_reg);
            end
            CASE_BOTH_HORZ:
            begin
                nx_next = NW'(ax5_reg);
            end
            CASE_FIRST_HORZ:
            begin
                nx_next  = NW'(c5_reg);
                dvx_next = PW'(dy5_reg);
            end
            CASE_SEC_HORZ:
            begin
                ny_next  = NW'(by5_reg);
                nx_next  = NW'(pbyax5_reg);
                dvx_next = PW'(ay5_reg);
            end
            CASE_GENERAL:
            begin
                if (den5_reg == '0)
                begin
                    par_next = 1'b1;
                end
                else
                begin
                    nx_next   = cax5_reg;
                    ny_next   = cay5_reg;
                    dvx_next  = den5_reg;
                    dvy_next  = den5_reg;
                    negx_next = 1'b1;
                    negy_next = 1'b1;
                end
            end
            default:
            begin
                par_next = 1'b0;
            end
        endcase
    end

    // divider pipeline, index 0 is stage 6
    logic          dv_reg   [0:NW];
    case_t         dsel_reg [0:NW];
    logic          dpar_reg [0:NW];
    logic [W-1:0]  dox_reg  [0:NW];
    logic [W-1:0]  doy_reg  [0:NW];
    logic          dsgx_reg [0:NW];
    logic          dsgy_reg [0:NW];
    logic [NW-1:0] numx_reg [0:NW];
    logic [NW-1:0] numy_reg [0:NW];
    logic [NW-1:0] quox_reg [0:NW];
    logic [NW-1:0] quoy_reg [0:NW];
    logic [PW-1:0] remx_reg [0:NW];
    logic [PW-1:0] remy_reg [0:NW];
    logic [PW-1:0] denx_reg [0:NW];
    logic [PW-1:0] deny_reg [0:NW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_reg[0] <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dsel_reg[0] <= sel5_reg;
            dpar_reg[0] <= par_next;
            dox_reg[0]  <= ox5_reg;
            doy_reg[0]  <= oy5_reg;
            dsgx_reg[0] <= negx_next ^ nx_next[NW-1] ^ dvx_next[PW-1];
            dsgy_reg[0] <= negy_next ^ ny_next[NW-1] ^ dvy_next[PW-1];
            numx_reg[0] <= nx_next[NW-1] ? NW'(-nx_next) : NW'(nx_next);
            numy_reg[0] <= ny_next[NW-1] ? NW'(-ny_next) : NW'(ny_next);
            denx_reg[0] <= dvx_next[PW-1] ? PW'(-dvx_next) : PW'(dvx_next);
            deny_reg[0] <= dvy_next[PW-1] ? PW'(-dvy_next) : PW'(dvy_next);
            quox_reg[0] <= '0;
            quoy_reg[0] <= '0;
            remx_reg[0] <= '0;
            remy_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < NW; k++)
    begin : g_div
        logic [PW:0] shx, shy, subx, suby;
        logic        gex, gey;

        assign shx  = {remx_reg[k], numx_reg[k][NW-1]};
        assign shy  = {remy_reg[k], numy_reg[k][NW-1]};
        assign subx = shx - {1'b0, denx_reg[k]};
        assign suby = shy - {1'b0, deny_reg[k]};
        assign gex  = shx >= {1'b0, denx_reg[k]};
        assign gey  = shy >= {1'b0, deny_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dsel_reg[k+1] <= dsel_reg[k];
                dpar_reg[k+1] <= dpar_reg[k];
                dox_reg[k+1]  <= dox_reg[k];
                doy_reg[k+1]  <= doy_reg[k];
                dsgx_reg[k+1] <= dsgx_reg[k];
                dsgy_reg[k+1] <= dsgy_reg[k];
                denx_reg[k+1] <= denx_reg[k];
                deny_reg[k+1] <= deny_reg[k];
                numx_reg[k+1] <= numx_reg[k] << 1;
                numy_reg[k+1] <= numy_reg[k] << 1;
                quox_reg[k+1] <= {quox_reg[k][NW-2:0], gex};
                quoy_reg[k+1] <= {quoy_reg[k][NW-2:0], gey};
                remx_reg[k+1] <= gex ? subx[PW-1:0] : shx[PW-1:0];
                remy_reg[k+1] <= gey ? suby[PW-1:0] : shy[PW-1:0];
            end
        end
    end

    // apply quotient sign
    logic ve1_reg;
    case_t sel_e1_reg;
    logic par_e1_reg;
    logic signed [W-1:0]  ox_e1_reg, oy_e1_reg;
    logic signed [NW:0]   qx_e1_reg, qy_e1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve1_reg <= 1'b0;
        end
        else if (adv)
        begin
            ve1_reg <= dv_reg[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel_e1_reg <= dsel_reg[NW];
            par_e1_reg <= dpar_reg[NW];
            ox_e1_reg  <= $signed(dox_reg[NW]);
            oy_e1_reg  <= $signed(doy_reg[NW]);
            qx_e1_reg  <= dsgx_reg[NW] ? -$signed({1'b0, quox_reg[NW]})
                                       : $signed({1'b0, quox_reg[NW]});
            qy_e1_reg  <= dsgy_reg[NW] ? -$signed({1'b0, quoy_reg[NW]})
                                       : $signed({1'b0, quoy_reg[NW]});
        end
    end

    // add offset back and saturate
    logic signed [NW+1:0] sx, sy;
    logic [W-1:0]         cx_next, cy_next;

    assign sx = (NW+2)'(qx_e1_reg) + (NW+2)'(ox_e1_reg);
    assign sy = (NW+2)'(qy_e1_reg) + (NW+2)'(oy_e1_reg);

    always_comb
    begin
        if (sx > SMAX)
            cx_next = SMAX[W-1:0];
        else if (sx < SMIN)
            cx_next = SMIN[W-1:0];
        else
            cx_next = sx[W-1:0];
        if (sy > SMAX)
            cy_next = SMAX[W-1:0];
        else if (sy < SMIN)
            cy_next = SMIN[W-1:0];
        else
            cy_next = sy[W-1:0];
    end

    logic         out_v_reg;
    logic [W-1:0] cx_reg, cy_reg;
    case_t        sel_out_reg;
    logic         par_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_v_reg <= ve1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            sel_out_reg <= sel_e1_reg;
            par_out_reg <= par_e1_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = OUT_W'({cy_reg, cx_reg});
    assign m_tuser  = {par_out_reg, sel_out_reg};

    `include "line_intersection_point_top_assert.svh"

    `LIP_ASSERT_ALWAYS(a_par_general,
        !m_tvalid || !par_out_reg || sel_out_reg == CASE_GENERAL,
        "parallel flag outside general case")
    `LIP_ASSERT_NEXT(a_stall_hold, !adv, $stable(m_tdata) && $stable(m_tuser),
        "result changed during stall")
    `LIP_ASSERT_NEXT(a_first_stage, s_tvalid && s_tready, v1_reg,
        "accepted request lost at first stage")

endmodule

// ----- sim/line_intersection_point_top_test.sv -----
`timescale 1ns / 1ps

module line_intersection_point_top_test;

    import lip_pkg::*;

    localparam int CB = 24;
    localparam int N_RANDOM = 2000;
    localparam int END_WAIT = 3 * CB + 12 + 100;

    typedef logic signed [CB-1:0] coord_t;
    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        case_t  sel;
        logic   par;
    } crossing_t;

    logic           clk;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [8*CB-1:0] s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    logic [47:0]    m_tdata;
    logic [3:0]     m_tuser;

    logic [8*CB-1:0] pending_lines[$];
    crossing_t       expected_crossings[$];
    int              n_errors = 0;
    int              n_checked = 0;
    int              n_case[7];
    int              n_parallel = 0;
    bit              stimulus_done = 0;
    int              s_idle = 0;
    int              m_idle = 0;

    line_intersection_point_top #(.COORD_BITS(CB)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    function automatic coord_t saturate(input wide_t v);
        wide_t lo;
        wide_t hi;
        lo = -(wide_t'(1) <<< (CB - 1));
        hi = (wide_t'(1) <<< (CB - 1)) - 1;
        if (v < lo)
        begin
            return lo[CB-1:0];
        end
        if (v > hi)
        begin
            return hi[CB-1:0];
        end
        return v[CB-1:0];
    endfunction

    function automatic crossing_t predict_crossing(input logic [8*CB-1:0] d);
        wide_t ox, oy, ax, ay, bx, by, ex, ey, dx, dy, c, den, rx, ry;
        crossing_t r;
        ox = $signed(d[0*CB +: CB]);
        oy = $signed(d[1*CB +: CB]);
        ax = $signed(d[2*CB +: CB]);
        ay = $signed(d[3*CB +: CB]);
        bx = $signed(d[4*CB +: CB]);
        by = $signed(d[5*CB +: CB]);
        ex = $signed(d[6*CB +: CB]);
        ey = $signed(d[7*CB +: CB]);
        ax = ax - ox;
        ay = ay - oy;
        bx = bx - ox;
        by = by - oy;
        ex = ex - ox;
        ey = ey - oy;
        dx = ex - bx;
        dy = ey - by;
        c = bx * ey - ex * by;
        rx = 0;
        ry = 0;
        r.par = 1'b0;
        if (ax == 0 && dx == 0)
        begin
            r.sel = CASE_BOTH_VERT;
            ry = ay;
        end
        else if (ax == 0)
        begin
            r.sel = CASE_FIRST_VERT;
            ry = (-c) / dx;
        end
        else if (dx == 0)
        begin
            r.sel = CASE_SEC_VERT;
            rx = bx;
            ry = (bx * ay) / ax;
        end
        else if (ay == 0 && dy == 0)
        begin
            r.sel = CASE_BOTH_HORZ;
            rx = ax;
        end
        else if (ay == 0)
        begin
            r.sel = CASE_FIRST_HORZ;
            rx = c / dy;
        end
        else if (dy == 0)
        begin
            r.sel = CASE_SEC_HORZ;
            ry = by;
            rx = (by * ax) / ay;
        end
        else
        begin
            r.sel = CASE_GENERAL;
            den = ay * dx - dy * ax;
            if (den == 0)
            begin
                r.par = 1'b1;
            end
            else
            begin
                ry = (-(c * ay)) / den;
                rx = (-(c * ax)) / den;
            end
        end
        r.x = saturate(rx + ox);
        r.y = saturate(ry + oy);
        return r;
    endfunction

    task automatic add_lines(input coord_t asx, input coord_t asy, input coord_t aex,
                             input coord_t aey, input coord_t bsx, input coord_t bsy,
                             input coord_t bex, input coord_t bey);
        pending_lines.insert(pending_lines.size(),
                             {bey, bex, bsy, bsx, aey, aex, asy, asx});
    endtask

    function automatic coord_t rand_coord();
        return coord_t'($urandom);
    endfunction

    function automatic coord_t grid_coord();
        return coord_t'((int'($urandom_range(0, 6)) - 3) * 256);
    endfunction

    function automatic coord_t mid_coord(input int span);
        return coord_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        coord_t mx, mn, asx, asy, adx, ady, bsx, bsy;
        int k;
        int kind;
        mx = {1'b0, {(CB-1){1'b1}}};
        mn = {1'b1, {(CB-1){1'b0}}};
        // directed: every case, parallel, extremes and saturation
        add_lines(0, 0, 0, 256, 256, 0, 256, 512);
        add_lines(0, 0, 0, 256, 256, 0, -256, 512);
        add_lines(0, 0, 256, 512, 768, 0, 768, 256);
        add_lines(0, 0, 256, 0, 0, 256, 512, 256);
        add_lines(0, 0, 256, 0, 0, 256, 512, -256);
        add_lines(0, 0, 256, 512, 0, 256, 512, 256);
        add_lines(0, 0, 256, 256, 0, 512, 512, 0);
        add_lines(0, 0, 256, 256, 256, 0, 512, 256);
        add_lines(mn, mn, mx, mx, mn, mx, mx, mn);
        add_lines(mx, mx, mn, mn, mx, mn, mn, mx);
        add_lines(mn, mn, mn, mx, mx, mn, mx, mx);
        add_lines(mn, 0, mx, 1, mn, 1, mx, 0);
        add_lines(mx, mn, mn, mn + coord_t'(1), mx, mx, mn, mx - coord_t'(1));
        add_lines(0, 0, 1, 2, 0, 1, 1, 0);
        add_lines(mx, mx, mx, mx, mn, mn, mn, mn);
        add_lines(0, 0, 1, mx, 2, mn, 1, mn);
        add_lines(-1, -1, -1, -1, -1, -1, -1, -1);
        add_lines(0, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2:
                begin
                    add_lines(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), rand_coord(), rand_coord());
                end
                3, 4:
                begin
                    add_lines(grid_coord(), grid_coord(), grid_coord(), grid_coord(),
                              grid_coord(), grid_coord(), grid_coord(), grid_coord());
                end
                5, 6:
                begin
                    asx = mid_coord(1 << 20);
                    asy = mid_coord(1 << 20);
                    bsx = mid_coord(1 << 20);
                    bsy = mid_coord(1 << 20);
                    adx = mid_coord(1 << 16);
                    ady = mid_coord(1 << 16);
                    case ($urandom_range(0, 3))
                        0: add_lines(asx, asy, asx, asy + ady, bsx, bsy, bsx + adx,
                                     bsy + ady);
                        1: add_lines(asx, asy, asx + adx, asy + ady, bsx, bsy, bsx,
                                     bsy + adx);
                        2: add_lines(asx, asy, asx + adx, asy, bsx, bsy, bsx + ady,
                                     bsy + adx);
                        default: add_lines(asx, asy, asx + ady, asy + adx, bsx, bsy,
                                           bsx + adx, bsy);
                    endcase
                end
                7, 8:
                begin
                    asx = mid_coord(1 << 20);
                    asy = mid_coord(1 << 20);
                    bsx = mid_coord(1 << 20);
                    bsy = mid_coord(1 << 20);
                    adx = mid_coord(1 << 18);
                    ady = mid_coord(1 << 18);
                    k = int'($urandom_range(0, 6)) - 3;
                    add_lines(asx, asy, asx + adx, asy + ady, bsx, bsy,
                              bsx + coord_t'(k * adx), bsy + coord_t'(k * ady));
                end
                default:
                begin
                    add_lines($urandom_range(0, 1) ? mx : mn, $urandom_range(0, 1) ? mx : mn,
                              rand_coord(), $urandom_range(0, 1) ? mx : mn,
                              $urandom_range(0, 1) ? mn : coord_t'(0), rand_coord(),
                              $urandom_range(0, 1) ? mx : coord_t'(1), rand_coord());
                end
            endcase
        end
        stimulus_done = 1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        logic [8*CB-1:0] next_data;
        logic next_valid;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_idle = 0;
        end
        else
        begin
            next_valid = s_tvalid;
            next_data = s_tdata;
            if (s_tvalid && s_tready)
            begin
                expected_crossings.insert(expected_crossings.size(),
                                          predict_crossing(s_tdata));
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (s_idle > 0)
                begin
                    s_idle--;
                end
                else if (pending_lines.size() > 0)
                begin
                    if (pending_lines.size() > 300 && $urandom_range(0, 5) == 0)
                    begin
                        s_idle = $urandom_range(1, 3) - 1;
                    end
                    else
                    begin
                        next_data = pending_lines.pop_front();
                        next_valid = 1'b1;
                    end
                end
            end
            s_tvalid <= next_valid;
            s_tdata  <= next_data;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        crossing_t exp_c;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            m_idle = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_crossings.size() == 0)
                begin
                    $error("result with no request pending: tdata %h tuser %h", m_tdata, m_tuser);
                    n_errors++;
                end
                else
                begin
                    exp_c = expected_crossings.pop_front();
                    n_checked++;
                    n_case[exp_c.sel]++;
                    n_parallel += int'(exp_c.par);
                    if (m_tdata[CB-1:0] !== exp_c.x)
                    begin
                        $error("cross_x expected %0d actual %0d", exp_c.x,
                               $signed(m_tdata[CB-1:0]));
                        n_errors++;
                    end
                    if (m_tdata[2*CB-1:CB] !== exp_c.y)
                    begin
                        $error("cross_y expected %0d actual %0d", exp_c.y,
                               $signed(m_tdata[2*CB-1:CB]));
                        n_errors++;
                    end
                    if (m_tuser[2:0] !== exp_c.sel)
                    begin
                        $error("case_taken expected %0d actual %0d", exp_c.sel, m_tuser[2:0]);
                        n_errors++;
                    end
                    if (m_tuser[3] !== exp_c.par)
                    begin
                        $error("parallel_flag expected %0d actual %0d", exp_c.par, m_tuser[3]);
                        n_errors++;
                    end
                end
            end
            if (m_idle > 0)
            begin
                m_idle--;
                m_tready <= 1'b0;
            end
            else if (pending_lines.size() > 300 && $urandom_range(0, 5) == 0)
            begin
                m_idle = $urandom_range(1, 3) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        wait (stimulus_done && pending_lines.size() == 0);
        @(posedge clk);
        while (s_tvalid || expected_crossings.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (END_WAIT) @(posedge clk);
        if (expected_crossings.size() > 0)
        begin
            $error("%0d results never arrived", expected_crossings.size());
            n_errors++;
        end
        $display("checked %0d crossings; cases vv %0d v1 %0d v2 %0d hh %0d h1 %0d h2 %0d gen %0d",
                 n_checked, n_case[0], n_case[1], n_case[2], n_case[3], n_case[4],
                 n_case[5], n_case[6]);
        $display("parallel requests %0d, mismatches %0d", n_parallel, n_errors);
        if (n_errors == 0)
        begin
            $display("line_intersection_point_top test passed");
        end
        else
        begin
            $display("line_intersection_point_top test failed");
        end
        $finish;
    end

    initial
    begin
        #2ms;
        $display("line_intersection_point_top test failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/lip_pkg.sv
hw/rtl/line_intersection_point_top.sv
sim/line_intersection_point_top_test.sv
